[sv/rlf_pkg.sv]
// Package for the radial linear falloff field block.
// Widths, register codes, payload structs and pipeline constants.
// No dependencies.
package rlf_pkg;

    localparam int COORD_BITS = 24;
    localparam int GAIN_BITS  = 16;
    localparam int ZD_W       = 26;
    localparam int OUT_W      = 15;
    localparam int DEPTH_W    = 16;
    localparam int NUM_GAINS  = 5;

    localparam int DIFF_W  = COORD_BITS;
    localparam int SQR_W   = 2 * DIFF_W;
    localparam int RAD_W   = SQR_W + 2;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int MAN_W   = DIFF_W + 2;
    localparam int DIST_W  = (ROOT_W > MAN_W) ? ROOT_W : MAN_W;
    localparam int SPAN_W  = ((DIST_W > ZD_W) ? DIST_W : ZD_W) + 1;
    localparam int PROD_W  = GAIN_BITS + SPAN_W;
    localparam int NUM_W   = PROD_W - 1;
    localparam int Q_W     = OUT_W + 1;
    localparam int DIV_W   = NUM_W + Q_W;

    localparam int SQ_PER    = 5;
    localparam int SQ_STAGES = (ROOT_W + SQ_PER - 1) / SQ_PER;
    localparam int DV_PER    = 4;
    localparam int DV_STAGES = (Q_W + DV_PER - 1) / DV_PER;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [OUT_W-1:0] OUT_MAX  = '1;
    localparam logic [ZD_W-1:0]  ZD_RESET = ZD_W'(256);

    typedef enum logic [2:0] {
        REG_MODE,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_ZERO_DIST,
        REG_VEL_GAINS,
        REG_SCALAR_GAINS,
        REG_DEPTH
    } t_reg_idx;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
        logic signed [COORD_BITS-1:0] query_z;
    } t_query;

    typedef struct packed {
        logic [OUT_W-1:0]   vel_u;
        logic [OUT_W-1:0]   vel_v;
        logic [OUT_W-1:0]   temperature;
        logic [OUT_W-1:0]   salinity;
        logic [OUT_W-1:0]   dye_level;
        logic [DEPTH_W-1:0] depth_out;
    } t_result;

    typedef struct packed {
        logic             vld;
        logic [MAN_W-1:0] man;
    } t_sq_side;

endpackage

[sv/radial_linear_falloff_field_top.sv]
// Top level of the radial linear falloff field block: register port,
// span and gain products, and the pipeline. Depends on rlf_pkg, rlf_dist,
// rlf_sqrt and rlf_div.
//
// Use: a query point is a transfer on i_in_valid/o_in_ready carrying i_query.
// Each query yields one result on o_out_valid/i_out_ready carrying o_result.
// Fourteen register stages: 3 front-end stages, 5 square root stages
// (5 root bits each), span, gain multiply and 4 divider stages (4 quotient
// bits each). Throughput is one query per cycle while results are accepted.
// The whole pipeline advances together; when the receiver holds off a valid
// result, every stage holds and o_in_ready drops, so nothing is lost or
// repeated. Reset empties the pipeline and loads register defaults
// (zero_distance 1.0, all else 0). Registers sit at byte address 8*index
// on the APB port. The user must write them only while the pipeline is
// empty; the block itself does not enforce this.
module radial_linear_falloff_field_top import rlf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_query            i_query,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_result           o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic                         r_mode;
    logic signed [COORD_BITS-1:0] r_center_x;
    logic signed [COORD_BITS-1:0] r_center_y;
    logic signed [COORD_BITS-1:0] r_center_z;
    logic [ZD_W-1:0]              r_zd;
    logic [2*GAIN_BITS-1:0]       r_vel_gains;
    logic [3*GAIN_BITS-1:0]       r_sc_gains;
    logic [DEPTH_W-1:0]           r_depth;

    logic                    en;
    t_reg_idx                reg_idx;
    logic                    front_vld;
    logic [RAD_W-1:0]        front_rad;
    logic [MAN_W-1:0]        front_man;
    t_sq_side                sq_in;
    t_sq_side                sq_out;
    logic [ROOT_W-1:0]       sq_root;
    logic [DIST_W-1:0]       dist_val;
    logic                    r_span_vld;
    logic signed [SPAN_W-1:0] r_span;
    logic                    r_num_vld;
    logic                    r_num_zero;
    logic [NUM_W-1:0]        r_num [NUM_GAINS];
    logic signed [GAIN_BITS-1:0] gain [NUM_GAINS];
    logic signed [PROD_W-1:0]    prod [NUM_GAINS];
    logic                    div_vld;
    logic [OUT_W-1:0]        div_res [NUM_GAINS];

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_center_x  <= '0;
            r_center_y  <= '0;
            r_center_z  <= '0;
            r_zd        <= ZD_RESET;
            r_vel_gains <= '0;
            r_sc_gains  <= '0;
            r_depth     <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_MODE:         r_mode      <= pwdata[0];
                REG_CENTER_X:     r_center_x  <= pwdata[COORD_BITS-1:0];
                REG_CENTER_Y:     r_center_y  <= pwdata[COORD_BITS-1:0];
                REG_CENTER_Z:     r_center_z  <= pwdata[COORD_BITS-1:0];
                REG_ZERO_DIST:    r_zd        <= pwdata[ZD_W-1:0];
                REG_VEL_GAINS:    r_vel_gains <= pwdata[2*GAIN_BITS-1:0];
                REG_SCALAR_GAINS: r_sc_gains  <= pwdata[3*GAIN_BITS-1:0];
                REG_DEPTH:        r_depth     <= pwdata[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE:         prdata = DATA_W'(r_mode);
            REG_CENTER_X:     prdata = DATA_W'(r_center_x[COORD_BITS-1:0]);
            REG_CENTER_Y:     prdata = DATA_W'(r_center_y[COORD_BITS-1:0]);
            REG_CENTER_Z:     prdata = DATA_W'(r_center_z[COORD_BITS-1:0]);
            REG_ZERO_DIST:    prdata = DATA_W'(r_zd);
            REG_VEL_GAINS:    prdata = DATA_W'(r_vel_gains);
            REG_SCALAR_GAINS: prdata = DATA_W'(r_sc_gains);
            REG_DEPTH:        prdata = DATA_W'(r_depth);
            default:          prdata = '0;
        endcase
    end

    assign en         = !div_vld || i_out_ready;
    assign o_in_ready = en;

    rlf_dist u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (i_in_valid),
        .i_query    (i_query),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_center_z (r_center_z),
        .o_vld      (front_vld),
        .o_rad      (front_rad),
        .o_man      (front_man)
    );

    assign sq_in.vld = front_vld;
    assign sq_in.man = front_man;

    rlf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (sq_in),
        .i_rad   (front_rad),
        .o_side  (sq_out),
        .o_root  (sq_root)
    );

    assign dist_val = r_mode ? DIST_W'(sq_out.man) : DIST_W'(sq_root);

    always_comb begin
        gain[0] = r_vel_gains[2*GAIN_BITS-1 -: GAIN_BITS];
        gain[1] = r_vel_gains[GAIN_BITS-1:0];
        gain[2] = r_sc_gains[3*GAIN_BITS-1 -: GAIN_BITS];
        gain[3] = r_sc_gains[2*GAIN_BITS-1 -: GAIN_BITS];
        gain[4] = r_sc_gains[GAIN_BITS-1:0];
        for (int g = 0; g < NUM_GAINS; g++) begin
            prod[g] = PROD_W'(gain[g]) * PROD_W'(r_span);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span_vld <= 1'b0;
            r_num_vld  <= 1'b0;
        end else if (en) begin
            r_span_vld <= sq_out.vld;
            r_num_vld  <= r_span_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_span     <= $signed(SPAN_W'(r_zd)) - $signed(SPAN_W'(dist_val));
            r_num_zero <= (r_zd == '0);
            for (int g = 0; g < NUM_GAINS; g++) begin
                r_num[g] <= (prod[g] > 0) ? prod[g][NUM_W-1:0] : '0;
            end
        end
    end

    rlf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_num_vld),
        .i_zero  (r_num_zero),
        .i_num   (r_num),
        .i_zd    (r_zd),
        .o_vld   (div_vld),
        .o_res   (div_res)
    );

    assign o_out_valid          = div_vld;
    assign o_result.vel_u       = div_res[0];
    assign o_result.vel_v       = div_res[1];
    assign o_result.temperature = div_res[2];
    assign o_result.salinity    = div_res[3];
    assign o_result.dye_level   = div_res[4];
    assign o_result.depth_out   = r_depth;

    a_span_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && sq_out.vld |=> r_span_vld)
        else $error("square root output lost before span stage");

endmodule

[sv/rlf_dist.sv]
// Front end: absolute coordinate differences, squares, Manhattan sum, radicand.
// Three register stages. Depends on rlf_pkg.
module rlf_dist import rlf_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  t_query                       i_query,
    input  logic signed [COORD_BITS-1:0] i_center_x,
    input  logic signed [COORD_BITS-1:0] i_center_y,
    input  logic signed [COORD_BITS-1:0] i_center_z,
    output logic                         o_vld,
    output logic [RAD_W-1:0]             o_rad,
    output logic [MAN_W-1:0]             o_man
);

    logic [2:0]            r_vld;
    logic [DIFF_W-1:0]     r_d [3];
    logic [DIFF_W-1:0]     n_d [3];
    logic [SQR_W-1:0]      r_sq [3];
    logic [MAN_W-1:0]      r_man2;
    logic [MAN_W-1:0]      r_man3;
    logic [RAD_W-1:0]      r_rad;
    logic signed [COORD_BITS:0] q_e [3];
    logic signed [COORD_BITS:0] c_e [3];
    logic signed [COORD_BITS:0] dif [3];

    always_comb begin
        q_e[0] = i_query.query_x;
        q_e[1] = i_query.query_y;
        q_e[2] = i_query.query_z;
        c_e[0] = i_center_x;
        c_e[1] = i_center_y;
        c_e[2] = i_center_z;
        for (int k = 0; k < 3; k++) begin
            dif[k] = q_e[k] - c_e[k];
            n_d[k] = DIFF_W'(dif[k][COORD_BITS] ? -dif[k] : dif[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k]  <= n_d[k];
                r_sq[k] <= SQR_W'(r_d[k]) * SQR_W'(r_d[k]);
            end
            r_man2 <= MAN_W'(r_d[0]) + MAN_W'(r_d[1]) + MAN_W'(r_d[2]);
            r_man3 <= r_man2;
            r_rad  <= RAD_W'(r_sq[0]) + RAD_W'(r_sq[1]) + RAD_W'(r_sq[2]);
        end
    end

    assign o_vld = r_vld[2];
    assign o_rad = r_rad;
    assign o_man = r_man3;

    a_vld_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_vld |=> r_vld[0])
        else $error("accepted transfer did not enter the front end");

endmodule

[sv/rlf_sqrt.sv]
// Pipelined digit-by-digit integer square root, a few root bits per stage.
// Carries the Manhattan distance and valid alongside. Depends on rlf_pkg.
module rlf_sqrt import rlf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_sq_side          i_side,
    input  logic [RAD_W-1:0]  i_rad,
    output t_sq_side          o_side,
    output logic [ROOT_W-1:0] o_root
);

    logic [SQ_STAGES-1:0] r_vld;
    logic [MAN_W-1:0]     r_man  [SQ_STAGES];
    logic [RAD_W-1:0]     r_rad  [SQ_STAGES];
    logic [REM_W-1:0]     r_rem  [SQ_STAGES];
    logic [ROOT_W-1:0]    r_root [SQ_STAGES];

    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
        logic [RAD_W-1:0]  a;
        logic [REM_W-1:0]  rem;
        logic [REM_W-1:0]  trial;
        logic [ROOT_W-1:0] root;
        logic              vin;
        logic [MAN_W-1:0]  min;

        always_comb begin
            if (s == 0) begin
                a    = i_rad;
                rem  = '0;
                root = '0;
                vin  = i_side.vld;
                min  = i_side.man;
            end else begin
                a    = r_rad[(s == 0) ? 0 : s-1];
                rem  = r_rem[(s == 0) ? 0 : s-1];
                root = r_root[(s == 0) ? 0 : s-1];
                vin  = r_vld[(s == 0) ? 0 : s-1];
                min  = r_man[(s == 0) ? 0 : s-1];
            end
            trial = '0;
            for (int j = 0; j < SQ_PER; j++) begin
                if (s * SQ_PER + j < ROOT_W) begin
                    rem   = {rem[REM_W-3:0], a[RAD_W-1 -: 2]};
                    a     = a << 2;
                    trial = {root, 2'b01};
                    if (rem >= trial) begin
                        rem  = rem - trial;
                        root = {root[ROOT_W-2:0], 1'b1};
                    end else begin
                        root = {root[ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s]  <= a;
                r_rem[s]  <= rem;
                r_root[s] <= root;
                r_man[s]  <= min;
            end
        end
    end

    assign o_side.vld = r_vld[SQ_STAGES-1];
    assign o_side.man = r_man[SQ_STAGES-1];
    assign o_root     = r_root[SQ_STAGES-1];

endmodule

[sv/rlf_div.sv]
// Pipelined restoring division of five numerators by zero_distance,
// with saturation and zero forcing at the end. Depends on rlf_pkg.
module rlf_div import rlf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic             i_zero,
    input  logic [NUM_W-1:0] i_num [NUM_GAINS],
    input  logic [ZD_W-1:0]  i_zd,
    output logic             o_vld,
    output logic [OUT_W-1:0] o_res [NUM_GAINS]
);

    logic [DV_STAGES-1:0] r_vld;
    logic [DV_STAGES-1:0] r_zero;
    logic [NUM_W-1:0]     r_rem [DV_STAGES][NUM_GAINS];
    logic [Q_W-1:0]       r_q   [DV_STAGES][NUM_GAINS];

    for (genvar s = 0; s < DV_STAGES; s++) begin : g_stage
        logic [NUM_W-1:0] rem [NUM_GAINS];
        logic [Q_W-1:0]   q   [NUM_GAINS];
        logic [DIV_W-1:0] cmp;
        logic             vin;
        logic             zin;

        always_comb begin
            if (s == 0) begin
                vin = i_vld;
                zin = i_zero;
            end else begin
                vin = r_vld[(s == 0) ? 0 : s-1];
                zin = r_zero[(s == 0) ? 0 : s-1];
            end
            cmp = '0;
            for (int g = 0; g < NUM_GAINS; g++) begin
                if (s == 0) begin
                    rem[g] = i_num[g];
                    q[g]   = '0;
                end else begin
                    rem[g] = r_rem[(s == 0) ? 0 : s-1][g];
                    q[g]   = r_q[(s == 0) ? 0 : s-1][g];
                end
                for (int j = 0; j < DV_PER; j++) begin
                    if (s * DV_PER + j < Q_W) begin
                        cmp = DIV_W'(i_zd) << (Q_W - 1 - (s * DV_PER + j));
                        if (DIV_W'(rem[g]) >= cmp) begin
                            rem[g] = rem[g] - cmp[NUM_W-1:0];
                            q[g]   = {q[g][Q_W-2:0], 1'b1};
                        end else begin
                            q[g]   = {q[g][Q_W-2:0], 1'b0};
                        end
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[s] <= zin;
                for (int g = 0; g < NUM_GAINS; g++) begin
                    r_rem[s][g] <= rem[g];
                    r_q[s][g]   <= q[g];
                end
            end
        end
    end

    always_comb begin
        for (int g = 0; g < NUM_GAINS; g++) begin
            if (r_zero[DV_STAGES-1]) begin
                o_res[g] = '0;
            end else if (r_q[DV_STAGES-1][g][Q_W-1]) begin
                o_res[g] = OUT_MAX;
            end else begin
                o_res[g] = r_q[DV_STAGES-1][g][OUT_W-1:0];
            end
        end
    end

    assign o_vld = r_vld[DV_STAGES-1];

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DV_STAGES-1] && r_zero[DV_STAGES-1] |->
            o_res[0] == '0 && o_res[4] == '0)
        else $error("zero distance transfer gave nonzero result");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_vld))
        else $error("divider pipeline moved during stall");

endmodule
